// File: rtl/core/frs_pkg.sv
// Shared types and constants for the fertigation relay sequencer.
// Holds the transaction structs, state and config records, op/phase codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frs_pkg;

  // Field widths
  localparam int TICK_W  = 12;
  localparam int VOL_W   = 16;
  localparam int CMD_W   = 8;
  localparam int RELAY_W = 6;
  localparam int PHASE_W = 3;
  localparam int LEVEL_W = 2;
  localparam int MARK_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Op codes of an input transaction
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  // Sequence phases
  localparam logic [PHASE_W-1:0] PH_START       = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FILL_STIR   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DRAIN       = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REFILL      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FINAL_DRAIN = 3'd5;

  // Water level codes
  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd2;

  // Fill/stir progress marker
  localparam logic [MARK_W-1:0] MK_NONE = 2'd0;
  localparam logic [MARK_W-1:0] MK_FILL = 2'd1;
  localparam logic [MARK_W-1:0] MK_STIR = 2'd2;

  // Relay bit positions (relay n sits at bit n-1)
  localparam int RLY_1 = 0;
  localparam int RLY_2 = 1;
  localparam int RLY_3 = 2;
  localparam int RLY_4 = 3;
  localparam int RLY_5 = 4;
  localparam int RLY_6 = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STIR_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VOL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_VOL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_VOL    = 3'd4;

  // Configuration reset values
  localparam logic [TICK_W-1:0] STIR_TICKS_RST   = 12'd900;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 12'd1500;
  localparam logic [VOL_W-1:0]  FILL_VOL_RST     = 16'd500;
  localparam logic [VOL_W-1:0]  DRAIN_VOL_RST    = 16'd500;
  localparam logic [VOL_W-1:0]  FINAL_VOL_RST    = 16'd400;

  localparam logic [TICK_W-1:0] TICK_MAX = 12'd4095;

  typedef struct packed {
    logic [1:0]       op;
    logic [CMD_W-1:0] cmd_value;
    logic [VOL_W-1:0] flow_in_total;
    logic [VOL_W-1:0] flow_out_total;
    logic             high_pin;
    logic             low_pin;
  } frs_in_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay_bits;
    logic [PHASE_W-1:0] phase_now;
    logic [LEVEL_W-1:0] level_state;
    logic               clear_flow;
    logic [CMD_W-1:0]   command_now;
  } frs_out_t;

  typedef struct packed {
    logic [TICK_W-1:0] stir_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [VOL_W-1:0]  fill_volume;
    logic [VOL_W-1:0]  drain_volume;
    logic [VOL_W-1:0]  final_drain_volume;
  } frs_cfg_t;

  typedef struct packed {
    logic [RELAY_W-1:0] relay;
    logic [PHASE_W-1:0] phase;
    logic [MARK_W-1:0]  marker;
    logic [TICK_W-1:0]  tick_count;
    logic [CMD_W-1:0]   command;
    logic [LEVEL_W-1:0] level;
  } frs_state_t;

  // Saturating timer increment
  function automatic logic [TICK_W-1:0] frs_tick_inc(input logic [TICK_W-1:0] cnt);
    frs_tick_inc = (cnt != TICK_MAX) ? cnt + 12'd1 : cnt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/frs_cfg_regs.sv
// Configuration register bank: stir/settle timers and the three volume limits.
// Depends on frs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frs_cfg_regs (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [frs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [frs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output frs_pkg::frs_cfg_t                  cfg
);

  // Write decode; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stir_ticks         <= frs_pkg::STIR_TICKS_RST;
      cfg.settle_ticks       <= frs_pkg::SETTLE_TICKS_RST;
      cfg.fill_volume        <= frs_pkg::FILL_VOL_RST;
      cfg.drain_volume       <= frs_pkg::DRAIN_VOL_RST;
      cfg.final_drain_volume <= frs_pkg::FINAL_VOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frs_pkg::CFG_STIR_TICKS:   cfg.stir_ticks   <= cfg_data[frs_pkg::TICK_W-1:0];
        frs_pkg::CFG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data[frs_pkg::TICK_W-1:0];
        frs_pkg::CFG_FILL_VOL:     cfg.fill_volume  <= cfg_data;
        frs_pkg::CFG_DRAIN_VOL:    cfg.drain_volume <= cfg_data;
        frs_pkg::CFG_FINAL_VOL:    cfg.final_drain_volume <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/frs_step.sv
// Next-state logic for one transaction: level protection plus one sequence step.
// Purely combinational. Depends on frs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frs_step (
  input  frs_pkg::frs_state_t state,
  input  frs_pkg::frs_cfg_t   cfg,
  input  frs_pkg::frs_in_t    item,
  output frs_pkg::frs_state_t state_next,
  output frs_pkg::frs_out_t   result
);

  logic [frs_pkg::RELAY_W-1:0] r;
  logic [frs_pkg::PHASE_W-1:0] ph;
  logic [frs_pkg::MARK_W-1:0]  sm;
  logic [frs_pkg::TICK_W-1:0]  tc;
  logic [frs_pkg::CMD_W-1:0]   cmd;
  logic [frs_pkg::LEVEL_W-1:0] lvl;
  logic                        clr;
  logic                        stir_hit;
  logic                        settle_hit;

  always_comb begin
    r          = state.relay;
    ph         = state.phase;
    sm         = state.marker;
    tc         = state.tick_count;
    cmd        = state.command;
    lvl        = state.level;
    clr        = 1'b0;
    stir_hit   = 1'b0;
    settle_hit = 1'b0;

    case (item.op)
      frs_pkg::OP_TICK: begin
        // Level protection: low water wins over high water
        if (!item.low_pin) begin
          r[frs_pkg::RLY_6] = 1'b0;
          lvl = frs_pkg::LVL_LOW;
        end else if (!item.high_pin) begin
          r[frs_pkg::RLY_2] = 1'b0;
          lvl = frs_pkg::LVL_HIGH;
        end else begin
          lvl = frs_pkg::LVL_NORMAL;
        end

        // One sequence step
        case (ph)
          frs_pkg::PH_START: begin
            clr = 1'b1;
            r[frs_pkg::RLY_1] = 1'b0;
            r[frs_pkg::RLY_2] = 1'b1;
            r[frs_pkg::RLY_5] = 1'b1;
            sm = frs_pkg::MK_NONE;
            ph = frs_pkg::PH_FILL_STIR;
          end
          frs_pkg::PH_FILL_STIR: begin
            // stir timer runs only until stirring is done
            if (sm != frs_pkg::MK_STIR) begin
              stir_hit = (tc >= cfg.stir_ticks);
              tc = frs_pkg::frs_tick_inc(tc);
              if (stir_hit) begin
                r[frs_pkg::RLY_5] = 1'b0;
                if (sm == frs_pkg::MK_FILL) begin
                  ph = frs_pkg::PH_SETTLE;
                  tc = '0;
                  r[frs_pkg::RLY_4] = 1'b1;
                end
                sm = frs_pkg::MK_STIR;
              end
            end
            // fill ends on volume or high water
            if (sm != frs_pkg::MK_FILL &&
                (item.flow_in_total >= cfg.fill_volume || lvl == frs_pkg::LVL_HIGH)) begin
              clr = 1'b1;
              r[frs_pkg::RLY_2] = 1'b0;
              if (sm == frs_pkg::MK_STIR) begin
                ph = frs_pkg::PH_SETTLE;
                tc = '0;
                r[frs_pkg::RLY_4] = 1'b1;
              end
              sm = frs_pkg::MK_FILL;
            end
          end
          frs_pkg::PH_SETTLE: begin
            settle_hit = (tc >= cfg.settle_ticks);
            tc = frs_pkg::frs_tick_inc(tc);
            if (settle_hit) begin
              r[frs_pkg::RLY_6] = 1'b1;
              r[frs_pkg::RLY_3] = 1'b1;
              ph = frs_pkg::PH_DRAIN;
              tc = '0;
            end
          end
          frs_pkg::PH_DRAIN: begin
            if (item.flow_out_total >= cfg.drain_volume || lvl == frs_pkg::LVL_LOW) begin
              r[frs_pkg::RLY_2] = 1'b1;
              r[frs_pkg::RLY_6] = 1'b0;
              r[frs_pkg::RLY_3] = 1'b0;
              ph = frs_pkg::PH_REFILL;
              clr = 1'b1;
            end
          end
          frs_pkg::PH_REFILL: begin
            if (item.flow_in_total >= cfg.fill_volume || lvl == frs_pkg::LVL_HIGH) begin
              r[frs_pkg::RLY_2] = 1'b0;
              r[frs_pkg::RLY_6] = 1'b1;
              r[frs_pkg::RLY_3] = 1'b1;
              ph = frs_pkg::PH_FINAL_DRAIN;
              clr = 1'b1;
            end
          end
          frs_pkg::PH_FINAL_DRAIN: begin
            // cycle done: close relays 2 to 6
            if (item.flow_out_total >= cfg.final_drain_volume ||
                lvl == frs_pkg::LVL_LOW) begin
              cmd = '0;
              r[frs_pkg::RELAY_W-1:frs_pkg::RLY_2] = '0;
              ph = frs_pkg::PH_START;
              clr = 1'b1;
            end
          end
          default: ;
        endcase
      end
      frs_pkg::OP_SET: begin
        // a new command restarts the sequence
        if (cmd != item.cmd_value) begin
          ph = frs_pkg::PH_START;
        end
        cmd = item.cmd_value;
      end
      frs_pkg::OP_STOP: begin
        cmd = '0;
        r[frs_pkg::RELAY_W-1:frs_pkg::RLY_2] = '0;
        ph = frs_pkg::PH_START;
        clr = 1'b1;
      end
      default: ;
    endcase
  end

  assign state_next.relay      = r;
  assign state_next.phase      = ph;
  assign state_next.marker     = sm;
  assign state_next.tick_count = tc;
  assign state_next.command    = cmd;
  assign state_next.level      = lvl;

  assign result.relay_bits  = r;
  assign result.phase_now   = ph;
  assign result.level_state = lvl;
  assign result.clear_flow  = clr;
  assign result.command_now = cmd;

endmodule

`default_nettype wire

// File: rtl/core/fertigation_relay_sequencer_unit.sv
// Top level of the fertigation relay sequencer: input register, step logic,
// sequencer state and result register. Depends on frs_pkg, frs_cfg_regs, frs_step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock while no result stalls and returns exactly
// one result for each, in order. The input register loads at the accepting
// edge; once the result register is free or being drained, the step logic
// feeds it, and the sequencer state is updated at the same edge. Throughput
// is one transaction per cycle while out_ready stays high; a stalled result
// holds in the result register and the input register keeps one more
// transaction behind it. Configuration writes take effect on the next clock;
// the user must keep them to idle periods, as the block does not enforce it.
module fertigation_relay_sequencer_unit (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  frs_pkg::frs_in_t                in_data,
  output logic                            out_valid,
  input  wire                             out_ready,
  output frs_pkg::frs_out_t               out_data,
  input  wire                             cfg_we,
  input  wire  [frs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [frs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  frs_pkg::frs_cfg_t   cfg;
  frs_pkg::frs_state_t state;
  frs_pkg::frs_state_t state_next;
  frs_pkg::frs_out_t   result;
  frs_pkg::frs_in_t    s1_data;
  logic                s1_valid;
  logic                s1_fire;

  frs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (s1_data),
    .state_next (state_next),
    .result     (result)
  );

  // Stage advance: result register free or being drained
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.relay      <= '0;
      state.phase      <= frs_pkg::PH_START;
      state.marker     <= frs_pkg::MK_NONE;
      state.tick_count <= '0;
      state.command    <= '0;
      state.level      <= frs_pkg::LVL_NORMAL;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  // Reported phase matches the stored phase after each step
  a_phase_mirror: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_data.phase_now == state.phase)
    else $error("result phase differs from stored phase");

  // Drain, refill and final drain follow settle in turn; settle zeroes the timer
  a_timer_idle: assert property (@(posedge clk) disable iff (rst)
    (state.phase == frs_pkg::PH_DRAIN || state.phase == frs_pkg::PH_REFILL ||
     state.phase == frs_pkg::PH_FINAL_DRAIN) |-> state.tick_count == '0)
    else $error("timer running outside fill and settle phases");

  // A stop closes relays 2 to 6, clears the command, requests a flow clear and returns to start
  a_stop_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_data.op == frs_pkg::OP_STOP) |=>
      (out_data.relay_bits[frs_pkg::RELAY_W-1:frs_pkg::RLY_2] == '0 &&
       out_data.command_now == '0 && out_data.clear_flow &&
       out_data.phase_now == frs_pkg::PH_START))
    else $error("stop did not close the sequence");

endmodule

`default_nettype wire
